/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks of the frame receiver.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/cfr_pkg.sv */
// ---------------------------------------------------------------------------
// cfr_pkg
// Types and constants shared by the checksummed frame receiver.
// ---------------------------------------------------------------------------
package cfr_pkg;

	localparam int CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_HEADER      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FOOTER      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HB_TYPE     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD = 3'd3;

	localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd60;

	// Frame positions.
	localparam logic [7:0] POS_LENGTH    = 8'd1;
	localparam logic [7:0] POS_KIND      = 8'd2;
	localparam logic [7:0] POS_ID_FIRST  = 8'd3;
	localparam logic [7:0] POS_ID_LAST   = 8'd6;
	localparam logic [7:0] POS_CNT_FIRST = 8'd7;
	localparam logic [7:0] POS_CNT_LAST  = 8'd10;

	// Header, length, checksum and footer bytes around the payload.
	localparam logic [7:0] FRAME_OVERHEAD = 8'd4;

	typedef enum logic [1:0] {
		STAT_HEARTBEAT = 2'd0,
		STAT_OTHER     = 2'd1,
		STAT_CSUM_BAD  = 2'd2,
		STAT_LEN_BAD   = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] header_value;
		logic [7:0] footer_value;
		logic [7:0] heartbeat_type;
		logic [7:0] max_payload;
	} cfg_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  frame_kind;
		logic [31:0] sender_id;
		logic [31:0] beat_count;
		logic [31:0] heartbeats_seen;
	} result_t;

endpackage

/* src/cfr_cfg_regs.sv */
// ---------------------------------------------------------------------------
// cfr_cfg_regs
// Configuration register file written through a simple write port.
// ---------------------------------------------------------------------------
module cfr_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [cfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [7:0]                         cfg_data,
	output cfr_pkg::cfg_t                      cfg
);

	cfr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_value   <= 8'd0;
			cfg_q.footer_value   <= 8'd0;
			cfg_q.heartbeat_type <= 8'd0;
			cfg_q.max_payload    <= cfr_pkg::MAX_PAYLOAD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cfr_pkg::REG_HEADER:      cfg_q.header_value   <= cfg_data;
				cfr_pkg::REG_FOOTER:      cfg_q.footer_value   <= cfg_data;
				cfr_pkg::REG_HB_TYPE:     cfg_q.heartbeat_type <= cfg_data;
				cfr_pkg::REG_MAX_PAYLOAD: cfg_q.max_payload    <= cfg_data;
				default: ; // Unmapped indexes are ignored.
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/cfr_deframer.sv */
// ---------------------------------------------------------------------------
// cfr_deframer
// Frame tracking state, field capture and checksum check, one byte a step.
// ---------------------------------------------------------------------------
module cfr_deframer #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	input  cfr_pkg::cfg_t     cfg,
	output logic              fire,
	output cfr_pkg::result_t  result
);

	localparam logic [7:0] LAST_POS = 8'(BUFFER_DEPTH - 1);

	logic        in_frame_q, in_frame_d;
	logic [7:0]  idx_q, idx_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  prev_q, prev_d;
	logic [7:0]  kind_q, kind_d;
	logic [31:0] id_q, id_d;
	logic [31:0] cnt_q, cnt_d;
	logic [31:0] hb_total_q, hb_total_d;

	logic [7:0]  len_n, kind_n;
	logic [31:0] id_n, cnt_n;
	logic        closing;
	logic        len_bad;
	cfr_pkg::status_t status;

	// Captures including the byte now being taken in.
	always_comb begin
		len_n  = (idx_q == cfr_pkg::POS_LENGTH) ? rx_byte : len_q;
		kind_n = (idx_q == cfr_pkg::POS_KIND) ? rx_byte : kind_q;
		id_n   = ((idx_q >= cfr_pkg::POS_ID_FIRST) && (idx_q <= cfr_pkg::POS_ID_LAST)) ?
			{id_q[23:0], rx_byte} : id_q;
		cnt_n  = ((idx_q >= cfr_pkg::POS_CNT_FIRST) && (idx_q <= cfr_pkg::POS_CNT_LAST)) ?
			{cnt_q[23:0], rx_byte} : cnt_q;
	end

	assign closing = in_frame_q && (({1'b0, idx_q} + 9'd1) == {1'b0, len_n});
	assign len_bad = (len_n < cfr_pkg::FRAME_OVERHEAD) ||
		((len_n - cfr_pkg::FRAME_OVERHEAD) > cfg.max_payload);

	always_comb begin
		if (sum_q != prev_q) begin
			status = cfr_pkg::STAT_CSUM_BAD;
		end else if (len_bad) begin
			status = cfr_pkg::STAT_LEN_BAD;
		end else if (kind_n == cfg.heartbeat_type) begin
			status = cfr_pkg::STAT_HEARTBEAT;
		end else begin
			status = cfr_pkg::STAT_OTHER;
		end
	end

	assign fire = step && closing && (rx_byte == cfg.footer_value);

	always_comb begin
		in_frame_d = in_frame_q;
		idx_d      = idx_q;
		len_d      = len_q;
		sum_d      = sum_q;
		prev_d     = prev_q;
		kind_d     = kind_q;
		id_d       = id_q;
		cnt_d      = cnt_q;
		hb_total_d = hb_total_q;
		if (!in_frame_q) begin
			if (rx_byte == cfg.header_value) begin
				in_frame_d = 1'b1;
				idx_d      = cfr_pkg::POS_LENGTH;
				len_d      = 8'd0;
				sum_d      = 8'd0;
				prev_d     = rx_byte;
				kind_d     = 8'd0;
				id_d       = 32'd0;
				cnt_d      = 32'd0;
			end
		end else begin
			len_d  = len_n;
			kind_d = kind_n;
			id_d   = id_n;
			cnt_d  = cnt_n;
			if (closing) begin
				in_frame_d = 1'b0;
				idx_d      = 8'd0;
				if (fire && (status == cfr_pkg::STAT_HEARTBEAT)) begin
					hb_total_d = hb_total_q + 32'd1;
				end
			end else if (idx_q >= LAST_POS) begin
				in_frame_d = 1'b0;
				idx_d      = 8'd0;
			end else begin
				sum_d  = sum_q + prev_q;
				prev_d = rx_byte;
				idx_d  = idx_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			idx_q      <= 8'd0;
			len_q      <= 8'd0;
			sum_q      <= 8'd0;
			prev_q     <= 8'd0;
			kind_q     <= 8'd0;
			id_q       <= 32'd0;
			cnt_q      <= 32'd0;
			hb_total_q <= 32'd0;
		end else if (step) begin
			in_frame_q <= in_frame_d;
			idx_q      <= idx_d;
			len_q      <= len_d;
			sum_q      <= sum_d;
			prev_q     <= prev_d;
			kind_q     <= kind_d;
			id_q       <= id_d;
			cnt_q      <= cnt_d;
			hb_total_q <= hb_total_d;
		end
	end

	assign result.status          = status;
	assign result.frame_kind      = kind_n;
	assign result.sender_id       = id_n;
	assign result.beat_count      = cnt_n;
	assign result.heartbeats_seen = hb_total_d;

endmodule

/* src/checksummed_frame_receiver_core.sv */
// ---------------------------------------------------------------------------
// checksummed_frame_receiver_core
// Cuts length-prefixed frames with an additive checksum out of a byte stream.
// ---------------------------------------------------------------------------
//
//   channel   handshake            payload
//   -------   ------------------   ---------------------------------------
//   input     in_valid / in_stall  rx_byte
//   output    out_valid/out_stall  status, frame_kind, sender_id,
//                                  beat_count, heartbeats_seen
//   config    cfg_we               cfg_index, cfg_data
//
// One word is taken every cycle while in_stall is low. A word passes
// through the input register to the deframer, and the result of a frame
// is offered from the result register after the footer word advances.
// The input register advances whenever the result register is empty or is
// being emptied; while a result is stalled, a waiting input word stalls too.
// Reset clears the frame state and both valid flags and resets the config.
//
// Frame layout: header, total length L, type, four sender id words, four
// beat count words, further payload, checksum, footer. The checksum is the
// eight-bit sum of every word from the header up to the one before the
// checksum. A frame that closes on a word other than the footer, or that
// runs past the buffer depth, is dropped without a result.
// ---------------------------------------------------------------------------
module checksummed_frame_receiver_core #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Byte input channel.
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       rx_byte,
	// Result channel.
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       status,
	output logic [7:0]                       frame_kind,
	output logic [31:0]                      sender_id,
	output logic [31:0]                      beat_count,
	output logic [31:0]                      heartbeats_seen,
	// Configuration write port.
	input  logic                             cfg_we,
	input  logic [cfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [7:0]                       cfg_data
);

	cfr_pkg::cfg_t    cfg;
	cfr_pkg::result_t result;

	logic             valid_s1;
	logic [7:0]       rx_byte_s1;
	logic             advance;
	logic             step;
	logic             fire;

	logic             res_valid_q;
	cfr_pkg::result_t res_q;
	logic [31:0]      hb_seen_q;

	// The result register can take a new word when it is empty or when its
	// current word leaves on this edge.
	assign advance  = !res_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	cfr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cfr_deframer #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_deframer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (rx_byte_s1),
		.cfg     (cfg),
		.fire    (fire),
		.result  (result)
	);

	// Result register. The heartbeat total is kept reset so that the value
	// shown always follows the running count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			hb_seen_q   <= 32'd0;
		end else if (advance) begin
			res_valid_q <= fire;
			if (fire) begin
				hb_seen_q <= result.heartbeats_seen;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fire) begin
			res_q <= result;
		end
	end

	assign out_valid       = res_valid_q;
	assign status          = res_q.status;
	assign frame_kind      = res_q.frame_kind;
	assign sender_id       = res_q.sender_id;
	assign beat_count      = res_q.beat_count;
	assign heartbeats_seen = hb_seen_q;

endmodule

/* src/cfr_checker.sv */
// ---------------------------------------------------------------------------
// cfr_checker
// Port-level checks on the frame receiver, attached by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cfr_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_stall,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic [31:0] heartbeats_seen
);

	logic        out_valid_q;
	logic        out_stall_q;
	logic [31:0] hb_prev_q;
	logic        new_result;
	logic [31:0] hb_step;

	// Previous-cycle view of the result channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_stall_q <= 1'b0;
			hb_prev_q   <= 32'd0;
		end else begin
			out_valid_q <= out_valid;
			out_stall_q <= out_stall;
			hb_prev_q   <= heartbeats_seen;
		end
	end

	assign new_result = out_valid && (!out_valid_q || !out_stall_q);
	assign hb_step    = (status == cfr_pkg::STAT_HEARTBEAT) ? 32'd1 : 32'd0;

	// A held result keeps its status.
	`CFR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status), "stalled result changed")

	// With the output side free, the input side never stalls.
	`CFR_ASSERT_NOW(a_no_needless_stall, clk, arst_n, !out_stall, !in_stall, "input stalled while output free")

	// Each fresh result moves the heartbeat count by one exactly when it is a heartbeat.
	`CFR_ASSERT_NOW(a_hb_count, clk, arst_n, new_result, heartbeats_seen == hb_prev_q + hb_step, "heartbeat count step wrong")

endmodule

bind checksummed_frame_receiver_core cfr_checker u_cfr_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.status          (status),
	.heartbeats_seen (heartbeats_seen)
);
